### hdl/bba_pkg.sv
// ============================================================================
// bba_pkg
// Shared types and constants of the free-block bitmap allocator.
// ============================================================================
package bba_pkg;

    localparam int MAX_BLOCKS = 8192;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int TOT_W      = 14;
    localparam logic [TOT_W-1:0] TOTAL_RESET = TOT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        FUNC_FIND    = 2'd0,
        FUNC_MARK    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_RSVD  = 2'd3
    } stat_t;

    typedef struct packed {
        func_t            func;
        logic [BLK_W-1:0] block_number;
    } req_t;

    typedef struct packed {
        stat_t            status;
        logic [BLK_W-1:0] found_block;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR,
        S_RESP
    } ctl_state_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_FOUND,
        RES_FULL,
        RES_RANGE
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     scan_start;
        logic     scan_step;
        logic     rmw_rd;
        logic     rmw_wr;
        logic     res_ld;
        res_sel_t res_sel;
    } ctl_cmd_t;

    typedef struct packed {
        func_t in_func;
        logic  in_range;
        logic  hit;
        logic  hit_in_range;
        logic  exhausted;
    } dp_stat_t;

endpackage

### hdl/bba_ctrl.sv
// ============================================================================
// bba_ctrl
// Sequencer: accepts a request, runs the bitmap scan or the read-modify-write
// in the datapath and holds the response until it is taken.
// ============================================================================
module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  bba_pkg::dp_stat_t st,
    output bba_pkg::ctl_cmd_t cmd
);
    import bba_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    assign accept = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (st.in_func)
                        FUNC_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        FUNC_MARK, FUNC_RELEASE:
                        begin
                            state_next = st.in_range ? S_RMW_RD : S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (st.hit || st.exhausted)
                begin
                    state_next = S_RESP;
                end
            end
            S_RMW_RD:
            begin
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        rsp_valid      = 1'b0;
        cmd            = '0;
        cmd.res_sel    = RES_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = accept;
                if (accept)
                begin
                    unique case (st.in_func)
                        FUNC_FIND:
                        begin
                            cmd.scan_start = 1'b1;
                        end
                        FUNC_MARK, FUNC_RELEASE:
                        begin
                            if (!st.in_range)
                            begin
                                cmd.res_ld  = 1'b1;
                                cmd.res_sel = RES_RANGE;
                            end
                        end
                        default:
                        begin
                            cmd.res_ld  = 1'b1;
                            cmd.res_sel = RES_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.hit)
                begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = st.hit_in_range ? RES_FOUND : RES_FULL;
                end
                else if (st.exhausted)
                begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_FULL;
                end
            end
            S_RMW_RD:
            begin
                cmd.rmw_rd = 1'b1;
            end
            S_RMW_WR:
            begin
                cmd.rmw_wr  = 1'b1;
                cmd.res_ld  = 1'b1;
                cmd.res_sel = RES_OK;
            end
            S_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // one request in flight at a time
    a_no_accept_with_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted while a response is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready)
        else $error("ready right after an accepted request");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rmw_wr |-> $past(cmd.rmw_rd))
        else $error("bitmap write without the preceding read");

endmodule

### hdl/bba_datapath.sv
// ============================================================================
// bba_datapath
// Bitmap memory with per-word valid bits, scan counter, first-zero search,
// request and response registers, block total register.
// ============================================================================
module bba_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bba_pkg::TOT_W-1:0]     cfg_wdata,
    input  bba_pkg::req_t                 req_data,
    output bba_pkg::rsp_t                 rsp_data,
    input  bba_pkg::ctl_cmd_t             cmd,
    output bba_pkg::dp_stat_t             st
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] wvld_reg;       // word written since reset
    logic [TOT_W-1:0]      total_reg;
    req_t                  req_reg;
    rsp_t                  rsp_reg;
    logic [ADDR_W:0]       cnt_reg;        // scan address, one extra bit for done
    logic                  pend_reg;       // read data below belongs to a scan
    logic [ADDR_W-1:0]     pend_addr_reg;
    logic [WORD_BITS-1:0]  rdata_reg;
    logic                  rvld_reg;

    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     rmw_addr;
    logic [WORD_BITS-1:0]  word;
    logic [WORD_BITS-1:0]  bit_mask;
    logic [WORD_BITS-1:0]  wdata;
    logic [BIT_W-1:0]      zero_pos;
    logic [BLK_W-1:0]      found;

    assign rmw_addr = req_reg.block_number[BLK_W-1:BIT_W];
    assign rd_en    = (cmd.scan_step && !cnt_reg[ADDR_W]) || cmd.rmw_rd;
    assign rd_addr  = cmd.scan_step ? cnt_reg[ADDR_W-1:0] : rmw_addr;
    assign word     = rvld_reg ? rdata_reg : '0;
    assign bit_mask = WORD_BITS'(1) << req_reg.block_number[BIT_W-1:0];
    assign wdata    = (req_reg.func == FUNC_MARK) ? (word | bit_mask)
                                                  : (word & ~bit_mask);

    // lowest clear bit of the word under test
    always_comb
    begin
        zero_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                zero_pos = BIT_W'(i);
            end
        end
    end

    assign found = {pend_addr_reg, zero_pos};

    assign st.in_func      = req_data.func;
    assign st.in_range     = {1'b0, req_data.block_number} < total_reg;
    assign st.hit          = pend_reg && (word != '1);
    assign st.hit_in_range = {1'b0, found} < total_reg;
    assign st.exhausted    = !pend_reg && cnt_reg[ADDR_W];

    // memory array, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.rmw_wr)
        begin
            mem[rmw_addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            rvld_reg  <= wvld_reg[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_data;
        end
        if (cmd.res_ld)
        begin
            case (cmd.res_sel)
                RES_FOUND: rsp_reg <= '{status: STAT_OK,    found_block: found};
                RES_FULL:  rsp_reg <= '{status: STAT_FULL,  found_block: '0};
                RES_RANGE: rsp_reg <= '{status: STAT_RANGE, found_block: '0};
                default:   rsp_reg <= '{status: STAT_OK,    found_block: '0};
            endcase
        end
        if (cmd.scan_step)
        begin
            pend_addr_reg <= cnt_reg[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvld_reg  <= '0;
            total_reg <= TOTAL_RESET;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            if (cmd.rmw_wr)
            begin
                wvld_reg[rmw_addr] <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_reg <= !cnt_reg[ADDR_W];
                if (!cnt_reg[ADDR_W])
                begin
                    cnt_reg <= cnt_reg + (ADDR_W + 1)'(1);
                end
            end
        end
    end

    assign rsp_data = rsp_reg;

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && cmd.rmw_wr))
        else $error("bitmap read and write in the same cycle");

endmodule

### hdl/bitmap_block_allocator_unit.sv
// ============================================================================
// bitmap_block_allocator_unit
// First-fit free-block allocator over a one-bit-per-block bitmap.
// ============================================================================
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one request: func is
//   find lowest free block, mark block used, or release block. Every request
//   yields exactly one response on rsp_valid/rsp_ready/rsp_data.
//   cfg_we/cfg_wdata set total_blocks (reset 8192); write it only while idle.
//   Steps from acceptance to rsp_valid:
//     mark / release in range : word read, word write, respond
//     out of range, unused op : respond
//     find                    : scan words upward from word 0 until the
//                               first word holding a clear bit, or through
//                               the whole bitmap when it is full (one 32-bit
//                               word read per cycle from the bitmap RAM), then respond.
//   One request is in flight at a time; req_ready drops from acceptance
//   until the response is taken, so no new request is accepted before then.
//   Reset: bitmap reads as all free (per-word valid bits cleared at once,
//   no clearing pass), total_blocks returns to 8192.
//   A stalled receiver simply holds the response register; nothing is lost.
// ============================================================================
module bitmap_block_allocator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bba_pkg::TOT_W-1:0] cfg_wdata,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  bba_pkg::req_t             req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output bba_pkg::rsp_t             rsp_data
);
    import bba_pkg::*;

    ctl_cmd_t cmd;   // sequencer -> datapath
    dp_stat_t st;    // datapath -> sequencer

    // controller: request decode, scan / read-modify-write sequencing
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: bitmap RAM, scan counter, first-zero search, registers
    bba_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_data  (req_data),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

### tb/bba_alloc_checker.sv
// ============================================================================
// bba_alloc_checker
// Watches the request, response and config ports of the bitmap allocator,
// keeps its own copy of the used-block bitmap and the block total, and checks
// every response against the outcome it worked out for the matching request.
// ============================================================================
`timescale 1ns / 100ps

module bba_alloc_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bba_pkg::TOT_W-1:0] cfg_wdata,
    input  logic                      req_valid,
    input  logic                      req_ready,
    input  bba_pkg::req_t             req_data,
    input  logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  bba_pkg::rsp_t             rsp_data,
    output int                        pending,
    output int                        fail_count
);
    import bba_pkg::*;

    logic [MAX_BLOCKS-1:0] used_map;
    logic [TOT_W-1:0]      total_reg;
    rsp_t                  due_rsp_q[$];
    rsp_t                  want;
    int                    errs;

    // Outcome of one request; mark and release update the bitmap copy.
    function automatic rsp_t alloc_outcome(req_t r);
        int   lim;
        int   first_free;
        rsp_t o;
        lim = (int'(total_reg) > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_reg);
        o.status      = STAT_OK;
        o.found_block = '0;
        case (r.func)
            FUNC_FIND:
            begin
                first_free = MAX_BLOCKS;
                for (int n = MAX_BLOCKS - 1; n >= 0; n--)
                    if (!used_map[n])
                        first_free = n;
                if (first_free < lim)
                    o.found_block = BLK_W'(first_free);
                else
                    o.status = STAT_FULL;
            end
            FUNC_MARK, FUNC_RELEASE:
            begin
                if (int'(r.block_number) >= lim)
                    o.status = STAT_RANGE;
                else
                    used_map[r.block_number] = (r.func == FUNC_MARK);
            end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_map   = '0;
            total_reg  = TOTAL_RESET;
            due_rsp_q.delete();
            errs       = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // response first: it always belongs to an earlier request
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: response with no request waiting: status %0d block %0d",
                                 $realtime, rsp_data.status, rsp_data.found_block);
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp_data.status !== want.status ||
                        rsp_data.found_block !== want.found_block)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: status/block expected %0d/%0d, got %0d/%0d",
                                     $realtime, want.status, want.found_block,
                                     rsp_data.status, rsp_data.found_block);
                    end
                end
            end
            if (cfg_we)
                total_reg = cfg_wdata;
            if (req_valid && req_ready)
                due_rsp_q.push_back(alloc_outcome(req_data));
            pending    <= due_rsp_q.size();
            fail_count <= errs;
        end
    end

endmodule

### tb/tb_bitmap_block_allocator_unit.sv
// ============================================================================
// tb_bitmap_block_allocator_unit
// Drives requests and block-total writes into the allocator, stalls both
// channels in random bursts, and reports the checker's verdict at the end.
// ============================================================================
`timescale 1ns / 100ps

module tb_bitmap_block_allocator_unit;
    import bba_pkg::*;

    // Slowest request is a find over a full bitmap.
    localparam int SETTLE_CYCLES = WORD_COUNT + 16;
    // ~1.15k requests, each at worst a full-bitmap find, taken several times over.
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int TOT_MAX       = 2**TOT_W - 1;
    // low blocks marked used in the fill phase: 20 bitmap words
    localparam int FILL_BLOCKS   = 640;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [TOT_W-1:0] cfg_wdata  = '0;
    logic             req_valid  = 1'b0;
    logic             req_ready;
    req_t             req_data   = '0;
    logic             rsp_valid;
    logic             rsp_ready  = 1'b0;
    rsp_t             rsp_data;
    int               idle_pct   = 0;   // chance (%) of an idle burst, per side
    int               stall_left = 0;
    int               pending;
    int               fail_count;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bitmap_block_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    bba_alloc_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // Response side: ready drops in bursts of random length, independent of
    // rsp_valid, so stalls land on every phase of a request's life.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= (stall_left == 1);
        end
        else if (int'($urandom_range(0, 99)) < idle_pct)
        begin
            stall_left <= $urandom_range(1, 9);
            rsp_ready  <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // One request. Valid stays high from one request to the next unless an
    // idle burst is taken, so valid is never dropped and raised in one step.
    task automatic send_req(input func_t f, input int blk);
        if (int'($urandom_range(0, 99)) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{func: f, block_number: BLK_W'(blk)};
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Wait until every response is back and the allocator sits idle.
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_total(input int v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= TOT_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Block numbers: any 13-bit value, around the total's edge, or in range.
    function automatic int pick_block(input int lim);
        int v;
        case ($urandom_range(0, 3))
            0:
                v = $urandom_range(0, MAX_BLOCKS - 1);
            1:
            begin
                v = lim - 4 + int'($urandom_range(0, 7));
                if (v < 0)
                    v = 0;
                if (v > MAX_BLOCKS - 1)
                    v = MAX_BLOCKS - 1;
            end
            default:
                v = (lim > 0) ? int'($urandom_range(0, lim - 1))
                              : int'($urandom_range(0, MAX_BLOCKS - 1));
        endcase
        return v;
    endfunction

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int tot;
        int lim;
        int blk;
        int pick;
        int items;
        int count;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: fresh bitmap, reset total of 8192 ----
        idle_pct <= 20;
        send_req(FUNC_FIND, 0);                  // empty bitmap gives block 0
        send_req(FUNC_MARK, 0);
        send_req(FUNC_FIND, MAX_BLOCKS - 1);     // block number ignored for find
        send_req(FUNC_MARK, 0);                  // marking a used block is harmless
        send_req(FUNC_RELEASE, 5);               // releasing a free block too
        send_req(FUNC_MARK, MAX_BLOCKS - 1);
        send_req(FUNC_RELEASE, MAX_BLOCKS - 1);
        send_req(FUNC_NONE, MAX_BLOCKS - 1);     // unused op code does nothing

        // zero total: find is full, mark/release out of range
        set_total(0);
        send_req(FUNC_FIND, 0);
        send_req(FUNC_MARK, 0);
        send_req(FUNC_RELEASE, MAX_BLOCKS - 1);

        // total beyond capacity behaves as capacity
        set_total(TOT_MAX);
        send_req(FUNC_MARK, MAX_BLOCKS - 1);
        send_req(FUNC_FIND, 0);
        send_req(FUNC_RELEASE, MAX_BLOCKS - 1);

        // total of one: lowest free (1) sits at the total, so full
        set_total(1);
        send_req(FUNC_FIND, 0);
        send_req(FUNC_MARK, 1);
        send_req(FUNC_RELEASE, 0);
        send_req(FUNC_FIND, 0);

        // ---- fill the low blocks, with finds scanning ever deeper ----
        set_total(MAX_BLOCKS);
        idle_pct <= 10;
        for (int b = 0; b < FILL_BLOCKS; b++)
        begin
            send_req(FUNC_MARK, b);
            if (b % 64 == 63)
                send_req(FUNC_FIND, $urandom_range(0, MAX_BLOCKS - 1));
        end
        send_req(FUNC_FIND, 0);                  // first free block past the run
        send_req(FUNC_RELEASE, FILL_BLOCKS - 1);
        send_req(FUNC_FIND, 0);                  // hit in the last filled word
        set_total(FILL_BLOCKS - 1);
        send_req(FUNC_FIND, 0);                  // only low free block is at the total
        send_req(FUNC_MARK, FILL_BLOCKS - 2);
        send_req(FUNC_MARK, FILL_BLOCKS - 1);    // out of range now
        set_total(MAX_BLOCKS);
        send_req(FUNC_MARK, FILL_BLOCKS - 1);

        // ---- random phases over a bitmap with its low blocks used ----
        // Mostly release / find / mark-back cycles, so finds keep scanning
        // deep; the rest are lone finds, marks, releases and unused op codes.
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:       tot = MAX_BLOCKS;
                1:       tot = $urandom_range(MAX_BLOCKS + 1, TOT_MAX);
                2:       tot = $urandom_range(1, 64);
                3:       tot = 0;
                4:       tot = 1;
                5:       tot = $urandom_range(1, MAX_BLOCKS);
                6:       tot = TOT_MAX;
                7:       tot = $urandom_range(MAX_BLOCKS - 64, MAX_BLOCKS);
                default: tot = MAX_BLOCKS;
            endcase
            set_total(tot);
            lim   = (tot > MAX_BLOCKS) ? MAX_BLOCKS : tot;
            count = (ph == 3 || ph == 4) ? 25 : 60;
            // last phase runs with no idling on either side
            case ($urandom_range(0, 2))
                0:       idle_pct <= 0;
                1:       idle_pct <= 15;
                default: idle_pct <= 35;
            endcase
            if (ph == 8)
                idle_pct <= 0;
            items = 0;
            while (items < count)
            begin
                pick = $urandom_range(0, 99);
                blk  = pick_block(lim);
                if (pick < 5)
                begin
                    send_req(FUNC_NONE, $urandom_range(0, MAX_BLOCKS - 1));
                    items += 1;
                end
                else if (pick < 35)
                begin
                    send_req(FUNC_FIND, $urandom_range(0, MAX_BLOCKS - 1));
                    items += 1;
                end
                else if (pick < 65)
                begin
                    send_req(FUNC_RELEASE, blk);
                    send_req(FUNC_FIND, $urandom_range(0, MAX_BLOCKS - 1));
                    send_req(FUNC_MARK, blk);
                    items += 3;
                end
                else if (pick < 82)
                begin
                    send_req(FUNC_MARK, blk);
                    items += 1;
                end
                else
                begin
                    send_req(FUNC_RELEASE, blk);
                    items += 1;
                end
            end
        end

        // ---- wind down: all responses back, then let the block settle ----
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
